/* src/bilinear_table_interpolator_defines.svh */
// assertion macros for the bilinear table interpolator
`ifndef BILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH
`define BILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define BTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bti_pkg.sv */
// shared types and constants of the bilinear table interpolator
package bti_pkg;

    localparam int MAX_X_POINTS = 64;
    localparam int MAX_Y_POINTS = 64;
    localparam int XA_W   = $clog2(MAX_X_POINTS);
    localparam int YA_W   = $clog2(MAX_Y_POINTS);
    localparam int TA_W   = XA_W + YA_W;
    localparam int CNT_W  = 7;
    localparam int QDEPTH = 2;
    localparam int QA_W   = 1;
    localparam int PADDR_W = 3;
    localparam int REG_X_COUNT = 0;
    localparam int REG_Y_COUNT = 1;
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);
    localparam logic signed [31:0] FRAC_MAX = 32'sh4000_0000;
    localparam logic signed [31:0] FRAC_MIN = -32'sh4000_0000;

    typedef enum logic [1:0] {
        CMD_WR_X   = 2'd0,
        CMD_WR_Y   = 2'd1,
        CMD_WR_TAB = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         index_x;
        logic [5:0]         index_y;
        logic signed [31:0] load_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic               status;
    } t_out_item;

    typedef struct packed {
        t_cmd               op;
        logic [XA_W-1:0]    ix;
        logic [YA_W-1:0]    iy;
        logic signed [31:0] word;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
    } t_q_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* src/bilinear_table_interpolator.sv */
// top level of the bilinear table interpolator
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------
//  input     | i_in_valid / o_in_ready | i_in_data  (t_in_item)
//  output    | o_out_valid/ i_out_ready| o_out_data (t_out_item)
//  config    | psel/penable/pwrite     | paddr, pwdata, prdata
//
//  writes are done in the back end as they leave the queue; a query runs the serial
//  fraction divider (31 steps per axis, one bit a cycle) and two binary searches,
//  each probe passing through the S_PROBE and S_CMP states
//  reset clears control state; grid and table contents stay undefined until written
//  a two-entry queue takes items while the back end works or the output stalls, until full
module bilinear_table_interpolator import bti_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [CNT_W-1:0] r_x_count;
    logic [CNT_W-1:0] r_y_count;
    logic             q_valid;
    logic             q_pop;
    t_q_entry         q_entry;
    logic             cfg_wr;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1];
    assign prdata  = (reg_sel == 1'(REG_Y_COUNT)) ? {25'd0, r_y_count} : {25'd0, r_x_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_count <= COUNT_RESET;
            r_y_count <= COUNT_RESET;
        end else if (cfg_wr) begin
            if (reg_sel == 1'(REG_X_COUNT)) begin
                r_x_count <= pwdata[CNT_W-1:0];
            end else begin
                r_y_count <= pwdata[CNT_W-1:0];
            end
        end
    end

    bti_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_entry  (q_entry),
        .i_q_pop    (q_pop)
    );

    bti_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_q_pop     (q_pop),
        .i_x_count   (r_x_count),
        .i_y_count   (r_y_count),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* src/bti_front.sv */
// input side: accepts items, classifies them and queues them for the back end
module bti_front import bti_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_q_valid,
    output t_q_entry o_q_entry,
    input  logic     i_q_pop
);

    t_q_entry              r_mem [QDEPTH];
    logic [QA_W-1:0]       r_wr_ptr;
    logic [QA_W-1:0]       r_rd_ptr;
    logic [QA_W:0]         r_count;
    logic                  push;
    t_q_entry              entry;

    assign o_in_ready = (r_count != (QA_W+1)'(QDEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_entry  = r_mem[r_rd_ptr];

    always_comb begin
        entry.op   = t_cmd'(i_in_data.command);
        entry.ix   = i_in_data.index_x[XA_W-1:0];
        entry.iy   = i_in_data.index_y[YA_W-1:0];
        entry.word = i_in_data.load_value;
        entry.qx   = i_in_data.query_x;
        entry.qy   = i_in_data.query_y;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !i_q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_q_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/bti_div.sv */
// serial divider for the cell fraction, one quotient bit per cycle
module bti_div import bti_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_q,
    input  logic signed [31:0] i_lo,
    input  logic signed [31:0] i_hi,
    output t_div_stat          o_stat,
    output logic signed [31:0] o_frac
);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} t_dstate;

    t_dstate            r_state;
    logic [4:0]         r_cnt;
    logic [30:0]        r_a_lo;
    logic [34:0]        r_rem;
    logic [33:0]        r_d;
    logic [30:0]        r_q;
    logic               r_neg;
    logic               r_sat;

    logic signed [32:0] d33;
    logic signed [32:0] n33;
    logic [32:0]        dmag;
    logic signed [33:0] n34;
    logic signed [52:0] num;
    logic [51:0]        amag;
    logic               sat;
    logic [34:0]        rem_sh;
    logic               ge;
    logic signed [31:0] fq;

    always_comb begin
        d33  = $signed({i_hi[31], i_hi}) - $signed({i_lo[31], i_lo});
        n33  = $signed({i_q[31], i_q}) - $signed({i_lo[31], i_lo});
        dmag = d33[32] ? 33'(-d33) : 33'(d33);
        n34  = d33[32] ? -$signed({n33[32], n33}) : $signed({n33[32], n33});
        num  = $signed({{2{n34[33]}}, n34, 17'd0}) + $signed({20'd0, dmag});
        amag = num[52] ? ~num[51:0] : num[51:0];
        sat  = ({13'd0, amag} >= {dmag, 1'b0, 31'd0});
        rem_sh = {r_rem[33:0], r_a_lo[30]};
        ge     = (rem_sh >= {1'b0, r_d});
        fq     = r_neg ? ~$signed({1'b0, r_q}) : $signed({1'b0, r_q});
        if (r_sat) begin
            o_frac = r_neg ? FRAC_MIN : FRAC_MAX;
        end else if (fq > FRAC_MAX) begin
            o_frac = FRAC_MAX;
        end else if (fq < FRAC_MIN) begin
            o_frac = FRAC_MIN;
        end else begin
            o_frac = fq;
        end
        o_stat.busy = (r_state == D_RUN);
        o_stat.done = (r_state == D_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                D_IDLE, D_DONE: begin
                    if (i_start) begin
                        r_state <= D_RUN;
                        r_cnt   <= 5'd30;
                    end else begin
                        r_state <= D_IDLE;
                    end
                end
                D_RUN: begin
                    if (r_cnt == '0) begin
                        r_state <= D_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_state != D_RUN) begin
            r_a_lo <= amag[30:0];
            r_rem  <= {14'd0, amag[51:31]};
            r_d    <= {dmag, 1'b0};
            r_q    <= '0;
            r_neg  <= num[52];
            r_sat  <= sat;
        end else if (r_state == D_RUN) begin
            r_rem  <= ge ? (rem_sh - {1'b0, r_d}) : rem_sh;
            r_q    <= {r_q[29:0], ge};
            r_a_lo <= {r_a_lo[29:0], 1'b0};
        end
    end

endmodule

/* src/bti_back.sv */
// back end: grid and table stores, axis search, fractions and blending
`include "bilinear_table_interpolator_defines.svh"
module bti_back import bti_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_q_entry         i_q_entry,
    output logic             o_q_pop,
    input  logic [CNT_W-1:0] i_x_count,
    input  logic [CNT_W-1:0] i_y_count,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PROBE, S_CMP, S_RD_LO, S_RD_HI, S_RD_CAP, S_CHECK,
        S_FX_WAIT, S_FY_WAIT, S_TAB, S_MUL, S_ADD, S_DONE
    } t_state;

    logic signed [31:0] r_xg [MAX_X_POINTS];
    logic signed [31:0] r_yg [MAX_Y_POINTS];
    logic signed [31:0] r_tab [MAX_X_POINTS*MAX_Y_POINTS];
    logic signed [31:0] r_xg_rd;
    logic signed [31:0] r_yg_rd;
    logic signed [31:0] r_tab_rd;

    t_state             r_state;
    t_q_entry           r_item;
    logic               r_axis;
    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_len;
    logic [XA_W-1:0]    r_cell;
    logic [XA_W-1:0]    r_ix;
    logic [YA_W-1:0]    r_iy;
    logic signed [31:0] r_x1, r_x2, r_y1, r_y2;
    logic signed [31:0] r_fx, r_fy;
    logic signed [31:0] r_t [4];
    logic [2:0]         r_cnt;
    logic [1:0]         r_lstep;
    logic signed [64:0] r_prod;
    logic signed [31:0] r_r0, r_r1, r_res;
    logic               r_stat;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CNT_W-1:0]   nx, ny, n_sel, half, idx7, lim;
    logic signed [31:0] g_rd, q_sel;
    logic [XA_W-1:0]    g_raddr;
    logic [TA_W-1:0]    tab_raddr;
    logic               x_we, y_we, t_we;
    logic               div_start, div_sel_y;
    t_div_stat          div_stat;
    logic signed [31:0] div_frac;
    logic signed [31:0] la, lb, lf;
    logic signed [64:0] prod_sh;
    logic signed [49:0] lsum;
    logic signed [31:0] lclamp;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c,
                                                   input int depth);
        logic [CNT_W-1:0] r;
        if (c < CNT_W'(2)) begin
            r = CNT_W'(2);
        end else if (c > CNT_W'(depth)) begin
            r = CNT_W'(depth);
        end else begin
            r = c;
        end
        return r;
    endfunction

    always_comb begin
        nx     = eff_count(i_x_count, MAX_X_POINTS);
        ny     = eff_count(i_y_count, MAX_Y_POINTS);
        n_sel  = r_axis ? ny : nx;
        q_sel  = r_axis ? r_item.qy : r_item.qx;
        g_rd   = r_axis ? r_yg_rd : r_xg_rd;
        half   = r_len >> 1;
        idx7   = (r_lo == '0) ? '0 : r_lo - 1'b1;
        lim    = n_sel - CNT_W'(2);
        o_q_pop = (r_state == S_IDLE) && i_q_valid;
        x_we   = o_q_pop && (i_q_entry.op == CMD_WR_X);
        y_we   = o_q_pop && (i_q_entry.op == CMD_WR_Y);
        t_we   = o_q_pop && (i_q_entry.op == CMD_WR_TAB);
        case (r_state)
            S_RD_LO: g_raddr = r_cell;
            S_RD_HI: g_raddr = r_cell + 1'b1;
            default: g_raddr = XA_W'(r_lo + half);
        endcase
        case (r_cnt[1:0])
            2'd0:    tab_raddr = {r_iy, r_ix};
            2'd1:    tab_raddr = {r_iy, r_ix + 1'b1};
            2'd2:    tab_raddr = {r_iy + 1'b1, r_ix};
            default: tab_raddr = {r_iy + 1'b1, r_ix + 1'b1};
        endcase
        div_sel_y = (r_state == S_FX_WAIT);
        div_start = ((r_state == S_CHECK) && (r_x1 != r_x2) && (r_y1 != r_y2))
                    || ((r_state == S_FX_WAIT) && div_stat.done);
        case (r_lstep)
            2'd0: begin
                la = r_t[0]; lb = r_t[1]; lf = r_fx;
            end
            2'd1: begin
                la = r_t[2]; lb = r_t[3]; lf = r_fx;
            end
            default: begin
                la = r_r0; lb = r_r1; lf = r_fy;
            end
        endcase
        prod_sh = (r_prod + 65'sd32768) >>> 16;
        lsum    = 50'(la) + prod_sh[49:0];
        if (lsum > 50'sd2147483647) begin
            lclamp = 32'sh7fff_ffff;
        end else if (lsum < -50'sd2147483648) begin
            lclamp = 32'sh8000_0000;
        end else begin
            lclamp = lsum[31:0];
        end
    end

    bti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_q     (div_sel_y ? r_item.qy : r_item.qx),
        .i_lo    (div_sel_y ? r_y1 : r_x1),
        .i_hi    (div_sel_y ? r_y2 : r_x2),
        .o_stat  (div_stat),
        .o_frac  (div_frac)
    );

    always_ff @(posedge i_clk) begin
        if (x_we) begin
            r_xg[i_q_entry.ix] <= i_q_entry.word;
        end
        r_xg_rd <= r_xg[g_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (y_we) begin
            r_yg[i_q_entry.iy] <= i_q_entry.word;
        end
        r_yg_rd <= r_yg[g_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tab[{i_q_entry.iy, i_q_entry.ix}] <= i_q_entry.word;
        end
        r_tab_rd <= r_tab[tab_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && i_q_entry.op == CMD_QUERY) begin
                        r_item  <= i_q_entry;
                        r_axis  <= 1'b0;
                        r_lo    <= '0;
                        r_len   <= nx;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_len == '0) begin
                        r_cell  <= (idx7 > lim) ? lim[XA_W-1:0] : idx7[XA_W-1:0];
                        r_state <= S_RD_LO;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (g_rd <= q_sel) begin
                        r_lo  <= r_lo + half + 1'b1;
                        r_len <= r_len - half - 1'b1;
                    end else begin
                        r_len <= half;
                    end
                    r_state <= S_PROBE;
                end
                S_RD_LO: r_state <= S_RD_HI;
                S_RD_HI: begin
                    if (r_axis) begin
                        r_y1 <= g_rd;
                    end else begin
                        r_x1 <= g_rd;
                    end
                    r_state <= S_RD_CAP;
                end
                S_RD_CAP: begin
                    if (r_axis) begin
                        r_y2    <= g_rd;
                        r_iy    <= r_cell;
                        r_state <= S_CHECK;
                    end else begin
                        r_x2    <= g_rd;
                        r_ix    <= r_cell;
                        r_axis  <= 1'b1;
                        r_lo    <= '0;
                        r_len   <= ny;
                        r_state <= S_PROBE;
                    end
                end
                S_CHECK: begin
                    if (r_x1 == r_x2 || r_y1 == r_y2) begin
                        r_res   <= '0;
                        r_stat  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_FX_WAIT;
                    end
                end
                S_FX_WAIT: begin
                    if (div_stat.done) begin
                        r_fx    <= div_frac;
                        r_state <= S_FY_WAIT;
                    end
                end
                S_FY_WAIT: begin
                    if (div_stat.done) begin
                        r_fy    <= div_frac;
                        r_cnt   <= '0;
                        r_state <= S_TAB;
                    end
                end
                S_TAB: begin
                    if (r_cnt != '0) begin
                        r_t[r_cnt[1:0] - 2'd1] <= r_tab_rd;
                    end
                    if (r_cnt == 3'd4) begin
                        r_lstep <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL: begin
                    r_prod  <= 65'(lf) * (33'(lb) - 33'(la));
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    case (r_lstep)
                        2'd0:    r_r0 <= lclamp;
                        2'd1:    r_r1 <= lclamp;
                        default: begin
                            r_res  <= lclamp;
                            r_stat <= 1'b0;
                        end
                    endcase
                    if (r_lstep == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lstep <= r_lstep + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid        <= 1'b1;
                        r_out.interp_value <= r_res;
                        r_out.status       <= r_stat;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BTI_ASSERT_IMP(a_flag_zero, i_clk, i_rst_n, r_out_valid && r_out.status, r_out.interp_value == '0, "flagged result is not zero")
    `BTI_ASSERT_IMP(a_search_span, i_clk, i_rst_n, r_state == S_PROBE, ({1'b0, r_lo} + {1'b0, r_len}) <= {1'b0, n_sel}, "search window leaves the grid")
    `BTI_ASSERT_IMP(a_div_start, i_clk, i_rst_n, div_start, !div_stat.busy, "divider started while busy")
    `BTI_ASSERT_NXT(a_write_no_result, i_clk, i_rst_n, o_q_pop && i_q_entry.op != CMD_QUERY && !r_out_valid, !r_out_valid, "write produced a result")

endmodule
